/* src/btpp_pkg.sv */
// shared types, constants and the xterm palette table for the bit unpacker with palettes
// no dependencies; every other file imports this package
package btpp_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_BITS_PER_PIXEL = 2'd0;
  localparam logic [1:0] REG_PALETTE_MODE   = 2'd1;
  localparam logic [1:0] REG_ROW_WIDTH      = 2'd2;

  // palette modes
  localparam logic [2:0] PAL_XT8    = 3'd0;
  localparam logic [2:0] PAL_RAW    = 3'd1;
  localparam logic [2:0] PAL_RGB16  = 3'd2;
  localparam logic [2:0] PAL_GRAY   = 3'd3;
  localparam logic [2:0] PAL_BINARY = 3'd4;
  localparam logic [2:0] PAL_CLASS  = 3'd5;

  // register reset values
  localparam logic [5:0]  BPP_RESET       = 6'd8;
  localparam logic [2:0]  PALETTE_RESET   = PAL_XT8;
  localparam logic [15:0] ROW_WIDTH_RESET = 16'd16;

  // default counter widths and queue depth
  localparam int COLUMN_BITS_DEFAULT = 16;
  localparam int ROW_BITS_DEFAULT    = 16;
  localparam int QUEUE_DEPTH         = 4;

  // one pixel on its way out: raw value before the palette, color after it
  typedef struct packed {
    logic [31:0] data;
    logic [15:0] column;
    logic [15:0] row;
    logic        last;
  } pixel_t;

  typedef logic [23:0] xt8_lut_t [256];

  // xterm 256 color table as 24-bit bgr, built at elaboration
  function automatic xt8_lut_t build_xt8();
    xt8_lut_t lut;
    logic [7:0] lvl;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    int c;
    for (int n = 0; n < 256; n++) begin
      if (n < 16) begin
        lvl = ((n & 8) != 0) ? 8'hFF : 8'h7F;
        r = ((n & 1) != 0) ? lvl : 8'h00;
        g = ((n & 2) != 0) ? lvl : 8'h00;
        b = ((n & 4) != 0) ? lvl : 8'h00;
      end else if (n < 232) begin
        c = n - 16;
        r = 8'(((c / 36) * 510) / 12);
        g = 8'((((c % 36) / 6) * 510) / 12);
        b = 8'(((c % 6) * 510) / 12);
      end else begin
        r = 8'((n - 232) * 10 + 8);
        g = r;
        b = r;
      end
      lut[n] = {b, g, r};
    end
    return lut;
  endfunction

  localparam xt8_lut_t XT8_LUT = build_xt8();

endpackage

/* src/btpp_queue.sv */
// short first-in first-out queue with full and empty flags
// depends on btpp_pkg for the default depth
module btpp_queue
  import btpp_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_COUNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/btpp_unpack.sv */
// bit unpacker: slices queued bytes lsb first into pixel values, at most one per
// cycle while the output register has room, and tracks column and row; depends on btpp_pkg
module btpp_unpack
  import btpp_pkg::*;
#(
  parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT,
  parameter int ROW_BITS    = ROW_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  logic [7:0]  head_byte,
  output logic        head_pop,
  input  logic [5:0]  bits_per_pixel,
  input  logic [15:0] row_width,
  output logic        pix_valid,
  output pixel_t      pix,
  input  logic        pix_ready
);

  // working byte and accumulator
  logic [7:0]             cur;
  logic [3:0]             left;
  logic                   busy;
  logic [31:0]            acc;
  logic [5:0]             acc_count;
  logic [COLUMN_BITS-1:0] col;
  logic [ROW_BITS-1:0]    row_cnt;

  logic [5:0]  bw;
  logic [15:0] rw;
  logic [7:0]  src_byte;
  logic [3:0]  src_left;
  logic [31:0] src_acc;
  logic [5:0]  src_bits;
  logic [5:0]  need;
  logic [3:0]  take;
  logic [7:0]  chunk;
  logic [31:0] acc_new;
  logic [5:0]  bits_new;
  logic [3:0]  left_after;
  logic [7:0]  byte_after;
  logic [7:0]  rest;
  logic        complete;
  logic        more;
  logic        step;
  logic        out_space;
  logic [32:0] col_inc;
  logic [31:0] col_ext;
  logic [31:0] row_ext;

  // clamp the configuration
  always_comb begin
    if (bits_per_pixel == 6'd0) begin
      bw = 6'd1;
    end else if (bits_per_pixel > 6'd32) begin
      bw = 6'd32;
    end else begin
      bw = bits_per_pixel;
    end
    rw = (row_width == 16'd0) ? 16'd1 : row_width;
  end

  // pick the working byte or a fresh one; drop a stale partial on a new byte
  always_comb begin
    if (busy) begin
      src_byte = cur;
      src_left = left;
      src_acc  = acc;
      src_bits = acc_count;
    end else begin
      src_byte = head_byte;
      src_left = 4'd8;
      src_acc  = (acc_count >= bw) ? 32'd0 : acc;
      src_bits = (acc_count >= bw) ? 6'd0 : acc_count;
    end
  end

  // one slice: fill the accumulator up to one value or to the end of the byte
  always_comb begin
    need       = bw - src_bits;
    take       = (need > 6'(src_left)) ? src_left : need[3:0];
    chunk      = src_byte & 8'((9'd1 << take) - 9'd1);
    acc_new    = src_acc | (32'(chunk) << src_bits);
    bits_new   = src_bits + 6'(take);
    left_after = src_left - take;
    byte_after = 8'(src_byte >> take);
    rest       = byte_after & 8'((9'd1 << left_after) - 9'd1);
    complete   = (bits_new == bw);
    more       = complete && (6'(left_after) >= bw);
  end

  assign out_space = !pix_valid || pix_ready;
  assign step      = (busy || head_valid) && (out_space || !complete);
  assign head_pop  = step && !busy;

  // column and row bookkeeping
  assign col_inc = 33'(col) + 33'd1;
  assign col_ext = 32'(col);
  assign row_ext = 32'(row_cnt);

  // byte and accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      acc       <= '0;
      acc_count <= '0;
      col       <= '0;
      row_cnt   <= '0;
    end else if (step) begin
      busy <= more;
      if (complete) begin
        acc       <= more ? 32'd0 : 32'(rest);
        acc_count <= more ? 6'd0 : 6'(left_after);
        if (col_inc >= 33'(rw)) begin
          col <= '0;
          if (row_cnt != '1) begin
            row_cnt <= row_cnt + 1'b1;
          end
        end else begin
          col <= col_inc[COLUMN_BITS-1:0];
        end
      end else begin
        acc       <= acc_new;
        acc_count <= bits_new;
      end
    end
  end

  // working byte payload
  always_ff @(posedge clk) begin
    if (step && more) begin
      cur  <= byte_after;
      left <= left_after;
    end
  end

  // output register toward the palette
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (out_space) begin
      pix_valid <= step && complete;
    end
  end

  always_ff @(posedge clk) begin
    if (out_space && step && complete) begin
      pix.data   <= acc_new;
      pix.column <= col_ext[15:0];
      pix.row    <= row_ext[15:0];
      pix.last   <= !more;
    end
  end

endmodule

/* src/btpp_palette.sv */
// palette lookup: turns a raw pixel value into rgba, position passes along
// depends on btpp_pkg for mode codes and the xterm table
module btpp_palette
  import btpp_pkg::*;
(
  input  logic [2:0] palette_mode,
  input  pixel_t     raw,
  output pixel_t     colored
);

  logic [31:0] v;
  logic [4:0]  r5;
  logic [5:0]  g6;
  logic [4:0]  b5;
  logic [31:0] class_rgba;
  logic [31:0] rgba;

  assign v  = raw.data;
  assign r5 = v[4:0];
  assign g6 = v[10:5];
  assign b5 = v[15:11];

  // byte class coloring over the whole value
  always_comb begin
    if (v == 32'd0) begin
      class_rgba = 32'hFF00_0000;
    end else if (v < 32'h20 && v != 32'h09 && v != 32'h0A && v != 32'h0D) begin
      class_rgba = 32'hFF00_FF00;
    end else if (v < 32'h7F) begin
      class_rgba = 32'hFFFF_0000;
    end else if (v < 32'hFF) begin
      class_rgba = 32'hFF00_00FF;
    end else begin
      class_rgba = 32'hFFFF_FFFF;
    end
  end

  // mode select
  always_comb begin
    unique case (palette_mode)
      PAL_XT8:    rgba = {8'hFF, XT8_LUT[v[7:0]]};
      PAL_RAW:    rgba = v;
      PAL_RGB16:  rgba = {8'hFF, b5, {3{b5[0]}}, g6, {2{g6[0]}}, r5, {3{r5[0]}}};
      PAL_GRAY:   rgba = {8'hFF, v[7:0], v[7:0], v[7:0]};
      PAL_BINARY: rgba = (v != 32'd0) ? 32'hFFFF_FFFF : 32'd0;
      PAL_CLASS:  rgba = class_rgba;
      default:    rgba = 32'd0;
    endcase
  end

  always_comb begin
    colored      = raw;
    colored.data = rgba;
  end

endmodule

/* src/bitstream_to_pixel_palette.sv */
// top level of the bit unpacker with palettes: config registers and wiring
// depends on btpp_pkg, btpp_queue, btpp_unpack and btpp_palette
//
// Bytes enter through a short input queue at up to one per cycle. The unpacker
// takes one byte at a time and slices it lsb first into values of
// bits_per_pixel bits, producing at most one value per cycle while the output
// queue has room. That per-cycle slice in the unpacker sets the sustained rate.
// Each value is colored by the selected palette on its way into a short output
// queue; a pixel passes through the unpacker's output register and then the
// output queue before it reaches the result ports. last_of_byte marks the
// final pixel a byte completes. A partial value waits for more bytes. The user
// must write configuration only while the block is idle; the block itself
// does not enforce this.
module bitstream_to_pixel_palette
  import btpp_pkg::*;
#(
  parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT,
  parameter int ROW_BITS    = ROW_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  input  logic [7:0]  in_byte,
  output logic        full,
  input  logic        pop,
  output logic        empty,
  output logic [31:0] pixel_rgba,
  output logic [15:0] column,
  output logic [15:0] row,
  output logic        last_of_byte
);

  localparam int PIX_W = $bits(pixel_t);

  logic [5:0]  bits_per_pixel;
  logic [2:0]  palette_mode;
  logic [15:0] row_width;

  logic        in_empty;
  logic [7:0]  head_byte;
  logic        head_pop;
  logic        pix_valid;
  pixel_t      pix;
  pixel_t      colored;
  logic        out_full;
  pixel_t      out_pix;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_pixel <= BPP_RESET;
      palette_mode   <= PALETTE_RESET;
      row_width      <= ROW_WIDTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BITS_PER_PIXEL: bits_per_pixel <= cfg_data[5:0];
        REG_PALETTE_MODE:   palette_mode   <= cfg_data[2:0];
        REG_ROW_WIDTH:      row_width      <= cfg_data;
        default:            ;
      endcase
    end
  end

  // front: input byte queue
  btpp_queue #(
    .WIDTH(8),
    .DEPTH(QUEUE_DEPTH)
  ) u_in_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (in_byte),
    .full    (full),
    .pop     (head_pop),
    .rd_data (head_byte),
    .empty   (in_empty)
  );

  // back: unpacker
  btpp_unpack #(
    .COLUMN_BITS(COLUMN_BITS),
    .ROW_BITS   (ROW_BITS)
  ) u_unpack (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (!in_empty),
    .head_byte      (head_byte),
    .head_pop       (head_pop),
    .bits_per_pixel (bits_per_pixel),
    .row_width      (row_width),
    .pix_valid      (pix_valid),
    .pix            (pix),
    .pix_ready      (!out_full)
  );

  // palette on the way into the result queue
  btpp_palette u_palette (
    .palette_mode (palette_mode),
    .raw          (pix),
    .colored      (colored)
  );

  btpp_queue #(
    .WIDTH(PIX_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (pix_valid),
    .wr_data (colored),
    .full    (out_full),
    .pop     (pop),
    .rd_data (out_pix),
    .empty   (empty)
  );

  assign pixel_rgba   = out_pix.data;
  assign column       = out_pix.column;
  assign row          = out_pix.row;
  assign last_of_byte = out_pix.last;

endmodule

/* tb/btpp_pixel_checker.sv */
// pixel checker for bitstream_to_pixel_palette: predicts pixels from accepted bytes
// depends on btpp_pkg; watches the config port and both queue-style channels
module btpp_pixel_checker
  import btpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  input  logic [7:0]  in_byte,
  input  logic        full,
  input  logic        pop,
  input  logic        empty,
  input  logic [31:0] pixel_rgba,
  input  logic [15:0] column,
  input  logic [15:0] row,
  input  logic        last_of_byte,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the config registers
  logic [5:0]  bpp_reg;
  logic [2:0]  mode_reg;
  logic [15:0] width_reg;

  // shadow unpacker state
  logic [31:0] acc;
  int unsigned acc_count;
  logic [15:0] col_cnt;
  logic [15:0] row_cnt;

  // pixels predicted but not yet seen, oldest first
  pixel_t pixels_due[$];
  pixel_t want;
  int     errs;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // widen a 5 or 6 bit channel to 8 bits, filling the low bits with its lsb
  function automatic logic [7:0] widen(input logic [7:0] v, input int from);
    int sh;
    sh = 8 - from;
    return 8'((int'(v) << sh) | (((1 << sh) - 1) * int'(v[0])));
  endfunction

  // palette lookup: raw value to rgba, red in the low byte
  function automatic logic [31:0] palette_color(input logic [31:0] v, input logic [2:0] mode);
    int n;
    int c;
    int lvl;
    int r;
    int g;
    int b;
    case (mode)
      PAL_XT8: begin
        n = int'(v[7:0]);
        if (n < 16) begin
          lvl = v[3] ? 255 : 127;
          r = v[0] ? lvl : 0;
          g = v[1] ? lvl : 0;
          b = v[2] ? lvl : 0;
        end else if (n < 232) begin
          c = n - 16;
          r = (c / 36) * 510 / 12;
          g = ((c % 36) / 6) * 510 / 12;
          b = (c % 6) * 510 / 12;
        end else begin
          r = (n - 232) * 10 + 8;
          g = r;
          b = r;
        end
        return {8'hFF, 8'(b), 8'(g), 8'(r)};
      end
      PAL_RAW: return v;
      PAL_RGB16: return {8'hFF, widen({3'd0, v[15:11]}, 5), widen({2'd0, v[10:5]}, 6),
                         widen({3'd0, v[4:0]}, 5)};
      PAL_GRAY: return {8'hFF, v[7:0], v[7:0], v[7:0]};
      PAL_BINARY: return (v != 0) ? 32'hFFFF_FFFF : 32'h0;
      PAL_CLASS: begin
        if (v == 0) return 32'hFF00_0000;
        if (v < 32'h20 && v != 32'h09 && v != 32'h0A && v != 32'h0D) return 32'hFF00_FF00;
        if (v < 32'h7F) return 32'hFFFF_0000;
        if (v < 32'hFF) return 32'hFF00_00FF;
        return 32'hFFFF_FFFF;
      end
      default: return 32'h0;
    endcase
  endfunction

  // slice one byte lsb first and queue every pixel it completes
  function automatic void unpack_byte(input logic [7:0] b);
    int unsigned width;
    int          wrap;
    int unsigned take;
    int unsigned left;
    logic [31:0] bits;
    pixel_t      held;
    bit          have_held;
    width = (bpp_reg == 0) ? 1 : ((bpp_reg > 32) ? 32 : int'(bpp_reg));
    wrap  = (width_reg == 0) ? 1 : int'(width_reg);
    bits  = {24'd0, b};
    left  = 8;
    have_held = 1'b0;
    held = '0;
    // a partial value at least as wide as the current width is dropped
    if (acc_count >= width) begin
      acc = '0;
      acc_count = 0;
    end
    while (left > 0) begin
      take = width - acc_count;
      if (take > left) take = left;
      acc |= (bits & ((32'd1 << take) - 32'd1)) << acc_count;
      acc_count += take;
      bits >>= take;
      left -= take;
      if (acc_count == width) begin
        if (have_held) pixels_due.push_back(held);
        held.data   = palette_color(acc, mode_reg);
        held.column = col_cnt;
        held.row    = row_cnt;
        held.last   = 1'b0;
        have_held = 1'b1;
        acc = '0;
        acc_count = 0;
        // column wraps at the row width, row saturates
        if (int'(col_cnt) + 1 >= wrap) begin
          col_cnt = '0;
          if (row_cnt != 16'hFFFF) row_cnt = row_cnt + 16'd1;
        end else begin
          col_cnt = col_cnt + 16'd1;
        end
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      pixels_due.push_back(held);
    end
  endfunction

  // track config, predict on byte transfers, compare on pixel transfers
  always @(posedge clk) begin
    errs = 0;
    if (rst) begin
      bpp_reg   = BPP_RESET;
      mode_reg  = PALETTE_RESET;
      width_reg = ROW_WIDTH_RESET;
      acc       = '0;
      acc_count = 0;
      col_cnt   = '0;
      row_cnt   = '0;
      pixels_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_BITS_PER_PIXEL: bpp_reg   = cfg_data[5:0];
          REG_PALETTE_MODE:   mode_reg  = cfg_data[2:0];
          REG_ROW_WIDTH:      width_reg = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) unpack_byte(in_byte);
      if (pop && !empty) begin
        if (pixels_due.size() == 0) begin
          $error("pixel transfer with no pixel expected: rgba %h column %0d row %0d",
                 pixel_rgba, column, row);
          errs++;
        end else begin
          want = pixels_due.pop_front();
          if (pixel_rgba !== want.data) begin
            $error("pixel_rgba: expected %h, got %h", want.data, pixel_rgba);
            errs++;
          end
          if (column !== want.column) begin
            $error("column: expected %0d, got %0d", want.column, column);
            errs++;
          end
          if (row !== want.row) begin
            $error("row: expected %0d, got %0d", want.row, row);
            errs++;
          end
          if (last_of_byte !== want.last) begin
            $error("last_of_byte: expected %b, got %b", want.last, last_of_byte);
            errs++;
          end
        end
      end
    end
    fail_count <= fail_count + errs;
    pending    <= pixels_due.size();
  end

endmodule

/* tb/tb_bitstream_to_pixel_palette.sv */
// testbench top for bitstream_to_pixel_palette: clock, reset, byte and pop stimulus
// depends on btpp_pkg, the block and btpp_pixel_checker, which does all checking
module tb_bitstream_to_pixel_palette;
  import btpp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // palette codes with no palette behind them
  localparam logic [2:0] PAL_UNKNOWN_LO = 3'd6;
  localparam logic [2:0] PAL_UNKNOWN_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_BITS_PER_PIXEL;
  logic [15:0] cfg_data = '0;
  logic        push = 1'b0;
  logic [7:0]  in_byte = '0;
  logic        full;
  logic        pop = 1'b0;
  logic        empty;
  logic [31:0] pixel_rgba;
  logic [15:0] column;
  logic [15:0] row;
  logic        last_of_byte;
  int          fail_count;
  int          pending;

  // idle rates in percent for the byte side and the pixel side
  int send_idle = 0;
  int recv_stall = 0;

  always #10 clk = ~clk;

  bitstream_to_pixel_palette DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .in_byte(in_byte), .full(full),
    .pop(pop), .empty(empty),
    .pixel_rgba(pixel_rgba), .column(column), .row(row), .last_of_byte(last_of_byte)
  );

  btpp_pixel_checker pixel_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .in_byte(in_byte), .full(full),
    .pop(pop), .empty(empty),
    .pixel_rgba(pixel_rgba), .column(column), .row(row), .last_of_byte(last_of_byte),
    .fail_count(fail_count), .pending(pending)
  );

  // pixel side stalls at random
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_stall);
  end

  // one byte transfer, with a random gap ahead of it
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // stop sending and wait for every predicted pixel
  task automatic wait_pixels();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // settle the block, then write all three registers
  task automatic set_config(input logic [15:0] bpp, input logic [15:0] mode,
                            input logic [15:0] width);
    wait_pixels();
    repeat (20) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_BITS_PER_PIXEL;
    cfg_data  <= bpp;
    @(posedge clk);
    cfg_index <= REG_PALETTE_MODE;
    cfg_data  <= mode;
    @(posedge clk);
    cfg_index <= REG_ROW_WIDTH;
    cfg_data  <= width;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // mostly uniform bytes, with zero and all-ones favored
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic run_phase(input logic [15:0] bpp, input logic [15:0] mode,
                           input logic [15:0] width, input int n,
                           input int s_idle, input int r_stall);
    set_config(bpp, mode, width);
    send_idle = s_idle;
    recv_stall = r_stall;
    repeat (n) push_byte(rand_byte());
  endtask

  logic [7:0] xt8_bytes[8] = '{8'd0, 8'd7, 8'd8, 8'd15, 8'd16, 8'd231, 8'd232, 8'd255};
  logic [7:0] rgb_bytes[4] = '{8'hFF, 8'hFF, 8'h21, 8'h08};
  logic [7:0] class_bytes[8] = '{8'h00, 8'h09, 8'h0A, 8'h0D, 8'h01, 8'h20, 8'h7F, 8'hFF};
  int p;

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset config, xterm palette ranges
    foreach (xt8_bytes[i]) push_byte(xt8_bytes[i]);
    // directed: rgb565 lsb fill
    set_config(16, PAL_RGB16, 3);
    foreach (rgb_bytes[i]) push_byte(rgb_bytes[i]);
    // directed: byte class boundaries, control characters
    set_config(8, PAL_CLASS, 5);
    foreach (class_bytes[i]) push_byte(class_bytes[i]);

    // fixed phases over the register extremes and odd settings
    run_phase(1, PAL_BINARY, 5, 20, 0, 0);
    run_phase(0, PAL_GRAY, 0, 10, 52, 0);
    run_phase(3, PAL_XT8, 7, 20, 0, 52);
    run_phase(5, PAL_RGB16, 16'hFFFF, 20, 22, 22);

    // sender holds off mid-phase until the pipe is empty
    run_phase(12, PAL_CLASS, 9, 15, 52, 0);
    wait_pixels();
    repeat (15) push_byte(rand_byte());

    // column run-up, then a narrower row puts the column past the row width
    run_phase(8, PAL_GRAY, 1000, 20, 0, 0);
    run_phase(20, PAL_GRAY, 4, 3, 22, 22);
    // narrower pixels drop the partial value left above
    run_phase(3, PAL_RAW, 2, 20, 0, 52);
    run_phase(32, PAL_RAW, 3, 24, 52, 0);
    run_phase(63, PAL_RAW, 1, 12, 22, 22);
    run_phase(7, PAL_UNKNOWN_LO, 4, 10, 0, 0);
    run_phase(24, PAL_UNKNOWN_HI, 16'hFFFF, 12, 0, 52);

    // random settings and idle profiles
    repeat (6) begin
      p = $urandom_range(3);
      run_phase(($urandom_range(3) == 0) ? 16'($urandom_range(63)) : 16'($urandom_range(1, 12)),
                16'($urandom_range(7)),
                ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(20)),
                $urandom_range(8, 20),
                (p == 1) ? 52 : ((p == 3) ? 22 : 0),
                (p == 2) ? 52 : ((p == 3) ? 22 : 0));
    end

    // one pixel per row, eight rows per byte
    run_phase(1, 16'($urandom_range(5)), 1, 10, 0, 0);
    run_phase(16, PAL_CLASS, 3, 20, 22, 22);

    wait_pixels();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
